FILE: hdl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside reset.
`define ASSERT_CLK(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// Checks that an implication holds at the same clock edge.
`define ASSERT_IMPL(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("assertion failed");

`endif

FILE: hdl/tdvf_pkg.sv
package tdvf_pkg;

  // Configuration register indexes.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 12;
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_SEP = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_VOTE      = 1'b1;

  // Register widths and reset values.
  localparam int SEP_W  = 12;
  localparam int VOTE_W = 8;
  localparam logic [SEP_W-1:0]  SEP_RESET  = 12'd20;
  localparam logic [VOTE_W-1:0] VOTE_RESET = 8'd1;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEP,
    ST_CHK,
    ST_CRD,
    ST_CLD,
    ST_NEXT,
    ST_DX,
    ST_DY,
    ST_ACC,
    ST_VMUL,
    ST_EMIT,
    ST_EMPTY,
    ST_FIN
  } state_e;

  // Operations of the shared multiplier.
  typedef enum logic {
    OP_MUL,
    OP_SQDIFF
  } mul_op_e;

  typedef struct packed {
    logic    en;
    mul_op_e op;
  } mul_req_t;

endpackage

FILE: hdl/tdvf_ram.sv
module tdvf_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/tdvf_mul_unit.sv
module tdvf_mul_unit #(
  parameter int OPW = 12
) (
  input  logic                clk_i,
  input  tdvf_pkg::mul_req_t  req_i,
  input  logic [OPW-1:0]      a_i,
  input  logic [OPW-1:0]      b_i,
  output logic [2*OPW-1:0]    prod_o
);

  logic [OPW-1:0]   diff;
  logic [OPW-1:0]   opa;
  logic [OPW-1:0]   opb;
  logic [2*OPW-1:0] prod_q;

  // Absolute difference for the squared-distance operation.
  assign diff = (a_i > b_i) ? (a_i - b_i) : (b_i - a_i);

  // Operand selection for the single multiplier.
  always_comb begin
    case (req_i.op)
      tdvf_pkg::OP_SQDIFF: begin
        opa = diff;
        opb = diff;
      end
      default: begin
        opa = a_i;
        opb = b_i;
      end
    endcase
  end

  // The product holds until the next request.
  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      prod_q <= opa * opb;
    end
  end

  assign prod_o = prod_q;

endmodule

FILE: hdl/temporal_detection_vote_filter.sv
// Temporal vote filter over a sliding window of detection frames.
// Input channel: one detection rectangle per item (has_detection_i), with
// frame_end_i on the last item of a frame; an item with neither does nothing.
// An item is taken when in_valid_i is high and in_stall_o is low.
// Items that do not close a frame, or close one while the window is still
// filling, never stall the input. A frame end with a full window starts the vote,
// and in_stall_o stays high until the whole vote is done.
// The vote runs on one shared multiplier and one read port of the store;
// each compared pair passes through a read, dx squared, dy squared and
// accumulate step in that order.
// Output channel: one item per centre detection, in arrival order, or one
// item with entry_valid_o low for an empty centre frame. A result sits in
// an output register; while out_stall_i is high it holds and the vote waits.
// Reset clears the window, the counts and the output valid; the store itself is
// not cleared, since only written entries are read.
module temporal_detection_vote_filter #(
  parameter int WINDOW_FRAMES  = 5,
  parameter int MAX_DETECTIONS = 16,
  parameter int COORD_BITS     = 12
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [tdvf_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [tdvf_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [COORD_BITS-1:0]             det_x_i,
  input  logic [COORD_BITS-1:0]             det_y_i,
  input  logic [COORD_BITS-1:0]             det_width_i,
  input  logic [COORD_BITS-1:0]             det_height_i,
  input  logic                              has_detection_i,
  input  logic                              frame_end_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [COORD_BITS-1:0]             out_x_o,
  output logic [COORD_BITS-1:0]             out_y_o,
  output logic [COORD_BITS-1:0]             out_width_o,
  output logic [COORD_BITS-1:0]             out_height_o,
  output logic                              kept_o,
  output logic                              entry_valid_o,
  output logic                              last_of_frame_o
);

  localparam int SLOT_W  = $clog2(WINDOW_FRAMES);
  localparam int IDX_W   = (MAX_DETECTIONS > 1) ? $clog2(MAX_DETECTIONS) : 1;
  localparam int CNT_W   = $clog2(MAX_DETECTIONS + 1);
  localparam int FILL_W  = $clog2(WINDOW_FRAMES + 1);
  localparam int P_W     = $clog2(WINDOW_FRAMES + 1);
  localparam int ADDR_W  = SLOT_W + IDX_W;
  localparam int ENTRY_W = 4 * COORD_BITS;
  localparam int CMP_W   = $clog2((WINDOW_FRAMES - 1) * MAX_DETECTIONS + 1);
  localparam int OPW_A   = (COORD_BITS > tdvf_pkg::SEP_W) ? COORD_BITS : tdvf_pkg::SEP_W;
  localparam int OPW     = (OPW_A > CMP_W) ? OPW_A : CMP_W;
  localparam int PRW     = 2 * OPW;
  localparam int CENTRE  = (WINDOW_FRAMES - 1) / 2;

  tdvf_pkg::state_e state_q, state_d;

  logic [tdvf_pkg::SEP_W-1:0]  sep_q;
  logic [tdvf_pkg::VOTE_W-1:0] vote_q;
  logic [CNT_W-1:0]  cnt_q [WINDOW_FRAMES];
  logic [SLOT_W-1:0] newest_q;
  logic [FILL_W-1:0] filled_q;

  logic [CNT_W-1:0]   k_q;
  logic [P_W-1:0]     p_q;
  logic [CNT_W-1:0]   l_q;
  logic [CMP_W-1:0]   found_q;
  logic [CMP_W-1:0]   miss_q;
  logic [PRW-1:0]     sep2_q;
  logic [PRW-1:0]     dx2_q;
  logic [ENTRY_W-1:0] cen_q;
  logic [COORD_BITS-1:0] oy_q;

  logic                  out_valid_q;
  logic [ENTRY_W-1:0]    out_rect_q;
  logic                  kept_q;
  logic                  entry_valid_q;
  logic                  last_q;

  logic in_acc;
  logic start_vote;
  logic advance;
  logic out_free;
  logic [SLOT_W-1:0] next_slot;
  logic [SLOT_W-1:0] oldest;
  logic [SLOT_W-1:0] cslot;
  logic [SLOT_W-1:0] pslot;
  logic [CNT_W-1:0]  cnt_c;
  logic [CNT_W-1:0]  cnt_p;
  logic              pair_done;
  logic              pair_skip;
  logic              is_last;
  logic [PRW:0]      d2;

  logic [ADDR_W-1:0]  waddr;
  logic [ADDR_W-1:0]  raddr;
  logic               we;
  logic [ENTRY_W-1:0] rdata;

  tdvf_pkg::mul_req_t mreq;
  logic [OPW-1:0]     ma;
  logic [OPW-1:0]     mb;
  logic [PRW-1:0]     prod;

  // Adds two slot numbers below the window size, modulo the window size.
  function automatic logic [SLOT_W-1:0] slot_add(input logic [SLOT_W-1:0] a,
                                                  input logic [SLOT_W-1:0] b);
    logic [SLOT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (SLOT_W+1)'(WINDOW_FRAMES)) begin
      s = s - (SLOT_W+1)'(WINDOW_FRAMES);
    end
    return s[SLOT_W-1:0];
  endfunction

  // Window geometry.
  assign next_slot = (newest_q == SLOT_W'(WINDOW_FRAMES - 1)) ? '0 : newest_q + 1'b1;
  assign oldest    = next_slot;
  assign cslot     = slot_add(oldest, SLOT_W'(CENTRE));
  assign pslot     = slot_add(oldest, p_q[SLOT_W-1:0]);
  assign cnt_c     = cnt_q[cslot];
  assign cnt_p     = cnt_q[pslot];
  assign pair_done = (p_q > P_W'(2 * CENTRE));
  assign pair_skip = (p_q == P_W'(CENTRE)) || (l_q >= cnt_p);
  assign is_last   = ({1'b0, k_q} + 1'b1) == {1'b0, cnt_c};
  assign d2        = {1'b0, dx2_q} + {1'b0, prod};

  // Handshakes.
  assign in_stall_o = (state_q != tdvf_pkg::ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign start_vote = in_acc && frame_end_i &&
                      (filled_q >= FILL_W'(WINDOW_FRAMES - 1));
  assign advance    = (in_acc && frame_end_i && !start_vote) ||
                      (state_q == tdvf_pkg::ST_FIN);
  assign out_free   = !out_valid_q || !out_stall_i;

  // Store write of an incoming detection.
  assign we    = in_acc && has_detection_i && (cnt_q[newest_q] < CNT_W'(MAX_DETECTIONS));
  assign waddr = {newest_q, cnt_q[newest_q][IDX_W-1:0]};

  tdvf_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(2 ** ADDR_W)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i({det_x_i, det_y_i, det_width_i, det_height_i}),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  tdvf_mul_unit #(
    .OPW(OPW)
  ) u_mul (
    .clk_i (clk_i),
    .req_i (mreq),
    .a_i   (ma),
    .b_i   (mb),
    .prod_o(prod)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      tdvf_pkg::ST_IDLE:  if (start_vote) state_d = tdvf_pkg::ST_SEP;
      tdvf_pkg::ST_SEP:   state_d = tdvf_pkg::ST_CHK;
      tdvf_pkg::ST_CHK: begin
        state_d = (cnt_c == '0) ? tdvf_pkg::ST_EMPTY : tdvf_pkg::ST_CRD;
      end
      tdvf_pkg::ST_CRD:   state_d = tdvf_pkg::ST_CLD;
      tdvf_pkg::ST_CLD:   state_d = tdvf_pkg::ST_NEXT;
      tdvf_pkg::ST_NEXT: begin
        if (pair_done) begin
          state_d = tdvf_pkg::ST_VMUL;
        end else if (!pair_skip) begin
          state_d = tdvf_pkg::ST_DX;
        end
      end
      tdvf_pkg::ST_DX:    state_d = tdvf_pkg::ST_DY;
      tdvf_pkg::ST_DY:    state_d = tdvf_pkg::ST_ACC;
      tdvf_pkg::ST_ACC:   state_d = tdvf_pkg::ST_NEXT;
      tdvf_pkg::ST_VMUL:  state_d = tdvf_pkg::ST_EMIT;
      tdvf_pkg::ST_EMIT: begin
        if (out_free) begin
          state_d = is_last ? tdvf_pkg::ST_FIN : tdvf_pkg::ST_CRD;
        end
      end
      tdvf_pkg::ST_EMPTY: if (out_free) state_d = tdvf_pkg::ST_FIN;
      tdvf_pkg::ST_FIN:   state_d = tdvf_pkg::ST_IDLE;
      default:            state_d = tdvf_pkg::ST_IDLE;
    endcase
  end

  // Multiplier requests and store read address.
  always_comb begin
    mreq.en = 1'b0;
    mreq.op = tdvf_pkg::OP_MUL;
    ma      = '0;
    mb      = '0;
    raddr   = {pslot, l_q[IDX_W-1:0]};
    case (state_q)
      tdvf_pkg::ST_SEP: begin
        mreq.en = 1'b1;
        ma      = OPW'(sep_q);
        mb      = OPW'(sep_q);
      end
      tdvf_pkg::ST_CRD: begin
        raddr = {cslot, k_q[IDX_W-1:0]};
      end
      tdvf_pkg::ST_DX: begin
        mreq.en = 1'b1;
        mreq.op = tdvf_pkg::OP_SQDIFF;
        ma      = OPW'(cen_q[ENTRY_W-1 -: COORD_BITS]);
        mb      = OPW'(rdata[ENTRY_W-1 -: COORD_BITS]);
      end
      tdvf_pkg::ST_DY: begin
        mreq.en = 1'b1;
        mreq.op = tdvf_pkg::OP_SQDIFF;
        ma      = OPW'(cen_q[3*COORD_BITS-1 -: COORD_BITS]);
        mb      = OPW'(oy_q);
      end
      tdvf_pkg::ST_VMUL: begin
        mreq.en = 1'b1;
        ma      = OPW'(found_q);
        mb      = OPW'(vote_q);
      end
      default: begin
      end
    endcase
  end

  // Control state: sequencer, configuration, window and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tdvf_pkg::ST_IDLE;
      sep_q       <= tdvf_pkg::SEP_RESET;
      vote_q      <= tdvf_pkg::VOTE_RESET;
      newest_q    <= '0;
      filled_q    <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < WINDOW_FRAMES; i++) begin
        cnt_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          tdvf_pkg::REG_PIXEL_SEP: sep_q  <= cfg_data_i;
          tdvf_pkg::REG_VOTE:      vote_q <= cfg_data_i[tdvf_pkg::VOTE_W-1:0];
          default: begin
          end
        endcase
      end
      // The slot that opens is cleared; the building slot counts a stored detection.
      for (int i = 0; i < WINDOW_FRAMES; i++) begin
        if (advance && (next_slot == SLOT_W'(i))) begin
          cnt_q[i] <= '0;
        end else if (we && (newest_q == SLOT_W'(i))) begin
          cnt_q[i] <= cnt_q[i] + 1'b1;
        end
      end
      if (in_acc && frame_end_i && (filled_q < FILL_W'(WINDOW_FRAMES))) begin
        filled_q <= filled_q + 1'b1;
      end
      if (advance) begin
        newest_q <= next_slot;
      end
      if (out_free && ((state_q == tdvf_pkg::ST_EMIT) ||
                       (state_q == tdvf_pkg::ST_EMPTY))) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Vote datapath registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      tdvf_pkg::ST_CHK: begin
        sep2_q <= prod;
        k_q    <= '0;
      end
      tdvf_pkg::ST_CLD: begin
        cen_q   <= rdata;
        p_q     <= '0;
        l_q     <= '0;
        found_q <= '0;
        miss_q  <= '0;
      end
      tdvf_pkg::ST_NEXT: begin
        if (!pair_done && pair_skip) begin
          p_q <= p_q + 1'b1;
          l_q <= '0;
        end
      end
      tdvf_pkg::ST_DX: begin
        oy_q <= rdata[3*COORD_BITS-1 -: COORD_BITS];
      end
      tdvf_pkg::ST_DY: begin
        dx2_q <= prod;
      end
      tdvf_pkg::ST_ACC: begin
        if (d2 > {1'b0, sep2_q}) begin
          miss_q <= miss_q + 1'b1;
        end else begin
          found_q <= found_q + 1'b1;
        end
        l_q <= l_q + 1'b1;
      end
      tdvf_pkg::ST_EMIT: begin
        if (out_free) begin
          out_rect_q    <= cen_q;
          kept_q        <= !(PRW'(miss_q) > prod);
          entry_valid_q <= 1'b1;
          last_q        <= is_last;
          k_q           <= k_q + 1'b1;
        end
      end
      tdvf_pkg::ST_EMPTY: begin
        if (out_free) begin
          out_rect_q    <= '0;
          kept_q        <= 1'b0;
          entry_valid_q <= 1'b0;
          last_q        <= 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Output ports.
  assign out_valid_o     = out_valid_q;
  assign out_x_o         = out_rect_q[ENTRY_W-1 -: COORD_BITS];
  assign out_y_o         = out_rect_q[3*COORD_BITS-1 -: COORD_BITS];
  assign out_width_o     = out_rect_q[2*COORD_BITS-1 -: COORD_BITS];
  assign out_height_o    = out_rect_q[COORD_BITS-1:0];
  assign kept_o          = kept_q;
  assign entry_valid_o   = entry_valid_q;
  assign last_of_frame_o = last_q;

endmodule

FILE: hdl/tdvf_checker.sv
`include "assert_macros.svh"

module tdvf_checker #(
  parameter int COORD_BITS = 12
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_stall_o,
  input logic                  frame_end_i,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input logic [COORD_BITS-1:0] out_x_o,
  input logic                  kept_o,
  input logic                  entry_valid_o,
  input logic                  last_of_frame_o
);

  logic in_acc;
  logic out_hold;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_hold = out_valid_o && out_stall_i;

  // A stalled result keeps its payload.
  `ASSERT_CLK(a_out_hold, out_hold |=> (out_valid_o && $stable(out_x_o) && $stable(kept_o)))

  // An empty centre frame gives a single, rejected, zero result.
  `ASSERT_IMPL(a_empty, out_valid_o && !entry_valid_o,
               last_of_frame_o && !kept_o && (out_x_o == '0))

  // An item that does not close a frame never makes the block busy.
  `ASSERT_CLK(a_no_busy, (in_acc && !frame_end_i) |=> !in_stall_o)

  // No result appears while the block is taking items.
  `ASSERT_CLK(a_no_spurious, (!in_stall_o && !$past(in_stall_o) && !$past(out_valid_o))
              |-> !out_valid_o)

endmodule

bind temporal_detection_vote_filter tdvf_checker #(.COORD_BITS(COORD_BITS)) u_tdvf_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .frame_end_i    (frame_end_i),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .out_x_o        (out_x_o),
  .kept_o         (kept_o),
  .entry_valid_o  (entry_valid_o),
  .last_of_frame_o(last_of_frame_o)
);

FILE: tb/sv/tb_temporal_detection_vote_filter.sv
module tb_temporal_detection_vote_filter;

  localparam int WIN = 5;
  localparam int MAXD = 16;
  localparam int CB = 12;
  localparam int CENTER = (WIN - 1) / 2;

  typedef struct packed {
    logic [CB-1:0] x;
    logic [CB-1:0] y;
    logic [CB-1:0] w;
    logic [CB-1:0] h;
    logic          has_det;
    logic          fend;
  } det_item_t;

  typedef struct packed {
    logic [CB-1:0] x;
    logic [CB-1:0] y;
    logic [CB-1:0] w;
    logic [CB-1:0] h;
    logic          kept;
    logic          entry_valid;
    logic          last;
  } vote_res_t;

  logic clk_i, rst_ni;
  logic cfg_we_i;
  logic [tdvf_pkg::CFG_IDX_W-1:0] cfg_idx_i;
  logic [tdvf_pkg::CFG_DATA_W-1:0] cfg_data_i;
  logic in_valid_i, in_stall_o;
  logic [CB-1:0] det_x_i, det_y_i, det_width_i, det_height_i;
  logic has_detection_i, frame_end_i;
  logic out_valid_o, out_stall_i;
  logic [CB-1:0] out_x_o, out_y_o, out_width_o, out_height_o;
  logic kept_o, entry_valid_o, last_of_frame_o;

  temporal_detection_vote_filter #(
    .WINDOW_FRAMES(WIN), .MAX_DETECTIONS(MAXD), .COORD_BITS(CB)
  ) i_dut (.*);

  // Predictor state: the frame window and registers.
  logic [4*CB-1:0] win_store [WIN][MAXD];
  int unsigned     win_count [WIN];
  int unsigned     build_slot;
  int unsigned     frames_held;
  logic [tdvf_pkg::SEP_W-1:0]  sep_reg;
  logic [tdvf_pkg::VOTE_W-1:0] vote_reg;

  det_item_t pending_items[$];
  vote_res_t expected_votes[$];
  int mismatches = 0;
  int results_seen = 0;
  int votes_run = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Appends an item to the stimulus queue.
  task automatic queue_item(det_item_t it);
    pending_items.insert(pending_items.size(), it);
  endtask

  // Appends a result to the expected queue.
  task automatic expect_result(vote_res_t r);
    expected_votes.insert(expected_votes.size(), r);
  endtask

  // Vote over the centre frame of a full window.
  task automatic predict_vote();
    int unsigned oldest, cslot, slot, n;
    longint unsigned sep2, found, missed, dx, dy;
    logic [4*CB-1:0] c, o;
    vote_res_t r;
    oldest = (build_slot + 1) % WIN;
    cslot = (oldest + CENTER) % WIN;
    n = win_count[cslot];
    sep2 = longint'(sep_reg) * longint'(sep_reg);
    votes_run++;
    if (n == 0) begin
      r = '0;
      r.last = 1'b1;
      expect_result(r);
      return;
    end
    for (int k = 0; k < n; k++) begin
      c = win_store[cslot][k];
      found = 0;
      missed = 0;
      for (int p = 0; p <= 2 * CENTER; p++) begin
        if (p == CENTER) continue;
        slot = (oldest + p) % WIN;
        for (int l = 0; l < win_count[slot]; l++) begin
          o = win_store[slot][l];
          dx = (c[4*CB-1:3*CB] > o[4*CB-1:3*CB]) ? c[4*CB-1:3*CB] - o[4*CB-1:3*CB]
                                                 : o[4*CB-1:3*CB] - c[4*CB-1:3*CB];
          dy = (c[3*CB-1:2*CB] > o[3*CB-1:2*CB]) ? c[3*CB-1:2*CB] - o[3*CB-1:2*CB]
                                                 : o[3*CB-1:2*CB] - c[3*CB-1:2*CB];
          if (dx * dx + dy * dy > sep2) missed++;
          else found++;
        end
      end
      r.x = c[4*CB-1:3*CB];
      r.y = c[3*CB-1:2*CB];
      r.w = c[2*CB-1:CB];
      r.h = c[CB-1:0];
      r.kept = (missed > found * vote_reg) ? 1'b0 : 1'b1;
      r.entry_valid = 1'b1;
      r.last = (k + 1 == n);
      expect_result(r);
    end
  endtask

  // Update the window model for one accepted item.
  task automatic predict_item(det_item_t it);
    if (it.has_det && win_count[build_slot] < MAXD) begin
      win_store[build_slot][win_count[build_slot]] = {it.x, it.y, it.w, it.h};
      win_count[build_slot]++;
    end
    if (it.fend) begin
      if (frames_held < WIN) frames_held++;
      if (frames_held >= WIN) predict_vote();
      build_slot = (build_slot + 1) % WIN;
      win_count[build_slot] = 0;
    end
  endtask

  // Driver: presents queued items, holding them while stalled.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i      <= 1'b0;
      det_x_i         <= '0;
      det_y_i         <= '0;
      det_width_i     <= '0;
      det_height_i    <= '0;
      has_detection_i <= 1'b0;
      frame_end_i     <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) predict_item(pending_items.pop_front());
      if ((!in_valid_i || !in_stall_o) ) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid_i      <= 1'b1;
          det_x_i         <= pending_items[0].x;
          det_y_i         <= pending_items[0].y;
          det_width_i     <= pending_items[0].w;
          det_height_i    <= pending_items[0].h;
          has_detection_i <= pending_items[0].has_det;
          frame_end_i     <= pending_items[0].fend;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks results in order and randomizes the stall.
  always @(posedge clk_i) begin
    vote_res_t exp_r;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (expected_votes.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("ERROR: result with no expectation");
        end else begin
          exp_r = expected_votes.pop_front();
          if (exp_r !== {out_x_o, out_y_o, out_width_o, out_height_o, kept_o,
                         entry_valid_o, last_of_frame_o}) begin
            mismatches++;
            if (mismatches <= 10)
              $display("ERROR: exp %0d %0d %0d %0d k%b v%b l%b got %0d %0d %0d %0d k%b v%b l%b",
                       exp_r.x, exp_r.y, exp_r.w, exp_r.h, exp_r.kept,
                       exp_r.entry_valid, exp_r.last, out_x_o, out_y_o,
                       out_width_o, out_height_o, kept_o, entry_valid_o,
                       last_of_frame_o);
          end
        end
      end
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  function automatic det_item_t make_det(int x, int y, bit fend);
    det_item_t it;
    it.x = CB'(x);
    it.y = CB'(y);
    it.w = CB'($urandom_range(4095));
    it.h = CB'($urandom_range(4095));
    it.has_det = 1'b1;
    it.fend = fend;
    return it;
  endfunction

  function automatic det_item_t make_marker(bit fend);
    det_item_t it;
    it = '0;
    it.x = CB'($urandom_range(4095));
    it.y = CB'($urandom_range(4095));
    it.fend = fend;
    return it;
  endfunction

  // Queue a frame of n detections, mostly near a track point.
  task automatic queue_frame(int n, int cx, int cy, int jitter);
    int x, y;
    if (n == 0) begin
      queue_item(make_marker(1'b1));
      return;
    end
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(3) == 0) begin
        x = $urandom_range(4095);
        y = $urandom_range(4095);
      end else begin
        x = cx + $urandom_range(2 * jitter) - jitter;
        y = cy + $urandom_range(2 * jitter) - jitter;
        if (x < 0) x = 0;
        if (x > 4095) x = 4095;
        if (y < 0) y = 0;
        if (y > 4095) y = 4095;
      end
      if ($urandom_range(9) == 0) queue_item(make_marker(1'b0));
      queue_item(make_det(x, y, i == n - 1));
    end
  endtask

  task automatic wait_drained();
    while (pending_items.size() > 0 || in_valid_i || expected_votes.size() > 0)
      @(posedge clk_i);
    repeat (3000) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [tdvf_pkg::CFG_IDX_W-1:0] idx, int val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= tdvf_pkg::CFG_DATA_W'(val);
    if (idx == tdvf_pkg::REG_PIXEL_SEP) sep_reg = tdvf_pkg::SEP_W'(val);
    else if (idx == tdvf_pkg::REG_VOTE) vote_reg = tdvf_pkg::VOTE_W'(val);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Random frames: mostly tracked clusters, some noise, empty and overfull frames.
  task automatic queue_random_frames(int nframes);
    int cx, cy, n;
    cx = $urandom_range(4095);
    cy = $urandom_range(4095);
    for (int f = 0; f < nframes; f++) begin
      case ($urandom_range(9))
        0: n = 0;
        1: n = MAXD + $urandom_range(2);
        default: n = $urandom_range(1, 3);
      endcase
      queue_frame(n, cx, cy, $urandom_range(30));
    end
  endtask

  // Stimulus sequence.
  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = tdvf_pkg::REG_PIXEL_SEP;
    cfg_data_i = '0;
    for (int s = 0; s < WIN; s++) win_count[s] = 0;
    build_slot = 0;
    frames_held = 0;
    sep_reg = tdvf_pkg::SEP_RESET;
    vote_reg = tdvf_pkg::VOTE_RESET;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: field extremes, empty frames, a lone marker and overflow.
    send_idle_pct = 21;
    recv_idle_pct = 77;
    queue_item(make_marker(1'b0));
    queue_item(make_det(0, 0, 1'b1));
    queue_item(make_det(4095, 4095, 1'b1));
    queue_frame(0, 0, 0, 0);
    queue_item(make_det(10, 10, 1'b0));
    queue_item(make_det(4095, 0, 1'b1));
    queue_item(make_det(0, 4095, 1'b1));
    queue_frame(MAXD + 2, 20, 20, 5);
    queue_frame(0, 0, 0, 0);
    wait_drained();

    write_reg(tdvf_pkg::REG_PIXEL_SEP, 4095);
    write_reg(tdvf_pkg::REG_VOTE, 255);
    queue_random_frames(9);
    wait_drained();

    send_idle_pct = 77;
    recv_idle_pct = 21;
    write_reg(tdvf_pkg::REG_PIXEL_SEP, 0);
    write_reg(tdvf_pkg::REG_VOTE, 0);
    queue_random_frames(9);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(tdvf_pkg::REG_PIXEL_SEP, 25);
    write_reg(tdvf_pkg::REG_VOTE, 2);
    queue_random_frames(12);
    wait_drained();

    $display("Ran %0d votes with %0d results over four register settings,",
             votes_run, results_seen);
    $display("including empty, overfull and stalled frames.");
    if (mismatches == 0 && expected_votes.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #20000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
